// ===== sv/dtj_pkg.sv =====
// shared types, constants and saturating helpers for the degree-ten julia engine
package dtj_pkg;

  // number format: signed q24.24 in 48 bits
  localparam int unsigned QW    = 48;
  localparam int unsigned FRAC  = 24;

  // shared multiplier: 25 x 25 unsigned covers both the pixel step and the q halves
  localparam int unsigned MW    = 25;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned ACC_W = 51;

  // iteration limit and counter widths
  localparam int unsigned MAX_ITER = 256;
  localparam int unsigned CNT_W    = $clog2(MAX_ITER + 1);
  localparam int unsigned ITER_W   = 9;

  // pixel and config port widths
  localparam int unsigned PIX_W  = 12;
  localparam int unsigned STEP_W = 25;
  localparam int unsigned IDX_W  = 3;

  localparam logic [QW-1:0] Q_MAX      = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] Q_MIN      = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] ESC_LIMIT  = QW'(10) << FRAC;

  // register reset values
  localparam logic [STEP_W-1:0] PIXEL_STEP_RST = STEP_W'(72944);
  localparam logic [QW-1:0]     ORIGIN_RE_RST  = QW'(-25165824);
  localparam logic [QW-1:0]     ORIGIN_IM_RST  = QW'(-25165824);
  localparam logic [QW-1:0]     CONST_RE_RST   = QW'(-15099494);
  localparam logic [QW-1:0]     CONST_IM_RST   = QW'(167772160);

  // config register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_PIXEL_STEP = 3'd0,
    CFG_ORIGIN_RE  = 3'd1,
    CFG_ORIGIN_IM  = 3'd2,
    CFG_CONST_RE   = 3'd3,
    CFG_CONST_IM   = 3'd4
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_X,
    ST_INIT_XY,
    ST_INIT_Y,
    ST_MUL,
    ST_UPDATE
  } state_e;

  // product steps of one iteration, in issue order
  typedef enum logic [3:0] {
    STEP_SQ_ZR,
    STEP_SQ_ZI,
    STEP_X_Z,
    STEP_SQ_S2R,
    STEP_SQ_S2I,
    STEP_X_S2,
    STEP_SQ_WR,
    STEP_SQ_WI,
    STEP_X_W,
    STEP_M_RR,
    STEP_M_II,
    STEP_M_RI,
    STEP_M_IR
  } step_e;

  // phases of one q24.24 product
  localparam logic [2:0] PH_LATCH = 3'd0;
  localparam logic [2:0] PH_HH    = 3'd1;
  localparam logic [2:0] PH_HL    = 3'd2;
  localparam logic [2:0] PH_LH    = 3'd3;
  localparam logic [2:0] PH_LL    = 3'd4;
  localparam logic [2:0] PH_TAIL  = 3'd5;
  localparam logic [2:0] PH_ROUND = 3'd6;
  localparam logic [2:0] PH_ACT   = 3'd7;

  // clamp a 49-bit signed sum to 48 bits
  function automatic logic [QW-1:0] sat49(input logic [QW:0] v);
    logic [QW-1:0] r;
    if (v[QW] != v[QW-1]) begin
      r = v[QW] ? Q_MIN : Q_MAX;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // saturating add and subtract
  function automatic logic [QW-1:0] add_sat(input logic [QW-1:0] a, input logic [QW-1:0] b);
    return sat49({a[QW-1], a} + {b[QW-1], b});
  endfunction

  function automatic logic [QW-1:0] sub_sat(input logic [QW-1:0] a, input logic [QW-1:0] b);
    return sat49({a[QW-1], a} - {b[QW-1], b});
  endfunction

  // magnitude as unsigned, most negative value gives 2^47
  function automatic logic [QW-1:0] mag(input logic [QW-1:0] v);
    return v[QW-1] ? (~v + QW'(1)) : v;
  endfunction

endpackage

// ===== sv/degree_ten_julia_escape_time.sv =====
// degree-ten julia escape-time engine: pixel to start point, then z = z^10 + c
//
//  port group    direction  handshake                 word
//  ------------  ---------  ------------------------  ----------------------------------
//  pixel in      in         start high, busy low      pixel_x_i, pixel_y_i
//  result out    out        done_o strobe, 1 cycle    out_x_o, out_y_o, iterations_o,
//                                                     inside_res_o
//  config        in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one pixel at a time; busy stays high from accept until the result strobe.
// each iteration runs on one 25x25 multiplier that builds each q24.24 product from four
// partial products in the phases latch, hh, hl, lh, ll, tail, round and act, 13 products
// per iteration, plus an update state; an escaping z ends its iteration after two products.
// async active-low reset returns the sequencer to idle and the config registers to their defaults.
// the result is shown for one cycle and cannot be held off by the receiver.
module degree_ten_julia_escape_time (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel in
  input  logic                          start,
  output logic                          busy,
  input  logic [dtj_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [dtj_pkg::PIX_W-1:0]     pixel_y_i,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [dtj_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [dtj_pkg::QW-1:0]        cfg_wdata_i,
  // result out
  output logic                          done_o,
  output logic [dtj_pkg::PIX_W-1:0]     out_x_o,
  output logic [dtj_pkg::PIX_W-1:0]     out_y_o,
  output logic [dtj_pkg::ITER_W-1:0]    iterations_o,
  output logic                          inside_res_o
);

  localparam int unsigned QW = dtj_pkg::QW;

  // config registers
  logic [dtj_pkg::STEP_W-1:0] pixel_step_q;
  logic [QW-1:0]              origin_re_q, origin_im_q, const_re_q, const_im_q;

  // sequencer
  dtj_pkg::state_e            state_q, state_d;
  dtj_pkg::step_e             step_q, step_d;
  logic [2:0]                 ph_q, ph_d;
  logic [dtj_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic                       inside_q, inside_d;

  // datapath
  logic [dtj_pkg::PIX_W-1:0]  px_q, py_q;
  logic [QW-1:0]              zr_q, zi_q, s2r_q, s2i_q, wr_q, wi_q, tr_q, p0_q, q_q;
  logic [QW-1:0]              ma_q, mb_q;
  logic                       neg_q, hi_ovf_q;
  logic [dtj_pkg::ACC_W-1:0]  acc_q;
  logic [dtj_pkg::PW-1:0]     prod_q;
  logic [dtj_pkg::MW-1:0]     mul_a, mul_b;
  logic [QW-1:0]              op_a, op_b;
  logic [QW-1:0]              r2, rnd_mag, rnd_val;
  logic                       escape;

  // config writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_step_q <= dtj_pkg::PIXEL_STEP_RST;
      origin_re_q  <= dtj_pkg::ORIGIN_RE_RST;
      origin_im_q  <= dtj_pkg::ORIGIN_IM_RST;
      const_re_q   <= dtj_pkg::CONST_RE_RST;
      const_im_q   <= dtj_pkg::CONST_IM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtj_pkg::CFG_PIXEL_STEP: pixel_step_q <= cfg_wdata_i[dtj_pkg::STEP_W-1:0];
        dtj_pkg::CFG_ORIGIN_RE:  origin_re_q  <= cfg_wdata_i;
        dtj_pkg::CFG_ORIGIN_IM:  origin_im_q  <= cfg_wdata_i;
        dtj_pkg::CFG_CONST_RE:   const_re_q   <= cfg_wdata_i;
        dtj_pkg::CFG_CONST_IM:   const_im_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // operand select for the current product step
  always_comb begin
    op_a = zr_q;
    op_b = zr_q;
    case (step_q)
      dtj_pkg::STEP_SQ_ZR:  begin op_a = zr_q;  op_b = zr_q;  end
      dtj_pkg::STEP_SQ_ZI:  begin op_a = zi_q;  op_b = zi_q;  end
      dtj_pkg::STEP_X_Z:    begin op_a = zr_q;  op_b = zi_q;  end
      dtj_pkg::STEP_SQ_S2R: begin op_a = s2r_q; op_b = s2r_q; end
      dtj_pkg::STEP_SQ_S2I: begin op_a = s2i_q; op_b = s2i_q; end
      dtj_pkg::STEP_X_S2:   begin op_a = s2r_q; op_b = s2i_q; end
      dtj_pkg::STEP_SQ_WR:  begin op_a = wr_q;  op_b = wr_q;  end
      dtj_pkg::STEP_SQ_WI:  begin op_a = wi_q;  op_b = wi_q;  end
      dtj_pkg::STEP_X_W:    begin op_a = wr_q;  op_b = wi_q;  end
      dtj_pkg::STEP_M_RR:   begin op_a = wr_q;  op_b = s2r_q; end
      dtj_pkg::STEP_M_II:   begin op_a = wi_q;  op_b = s2i_q; end
      dtj_pkg::STEP_M_RI:   begin op_a = wr_q;  op_b = s2i_q; end
      dtj_pkg::STEP_M_IR:   begin op_a = wi_q;  op_b = s2r_q; end
      default: ;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      dtj_pkg::ST_INIT_X: begin
        mul_a = dtj_pkg::MW'(px_q);
        mul_b = pixel_step_q;
      end
      dtj_pkg::ST_INIT_XY: begin
        mul_a = dtj_pkg::MW'(py_q);
        mul_b = pixel_step_q;
      end
      dtj_pkg::ST_MUL: begin
        case (ph_q)
          dtj_pkg::PH_HH: begin
            mul_a = dtj_pkg::MW'(ma_q[QW-1:dtj_pkg::FRAC]);
            mul_b = dtj_pkg::MW'(mb_q[QW-1:dtj_pkg::FRAC]);
          end
          dtj_pkg::PH_HL: begin
            mul_a = dtj_pkg::MW'(ma_q[QW-1:dtj_pkg::FRAC]);
            mul_b = dtj_pkg::MW'(mb_q[dtj_pkg::FRAC-1:0]);
          end
          dtj_pkg::PH_LH: begin
            mul_a = dtj_pkg::MW'(ma_q[dtj_pkg::FRAC-1:0]);
            mul_b = dtj_pkg::MW'(mb_q[QW-1:dtj_pkg::FRAC]);
          end
          dtj_pkg::PH_LL: begin
            mul_a = dtj_pkg::MW'(ma_q[dtj_pkg::FRAC-1:0]);
            mul_b = dtj_pkg::MW'(mb_q[dtj_pkg::FRAC-1:0]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // product rounding: truncate toward zero, clamp, reapply sign
  always_comb begin
    if (hi_ovf_q || (acc_q > dtj_pkg::ACC_W'(dtj_pkg::Q_MIN))) begin
      rnd_mag = dtj_pkg::Q_MIN;
    end else begin
      rnd_mag = acc_q[QW-1:0];
    end
    if (neg_q) begin
      rnd_val = ~rnd_mag + QW'(1);
    end else begin
      rnd_val = rnd_mag[QW-1] ? dtj_pkg::Q_MAX : rnd_mag;
    end
  end

  // escape test on |z|^2
  assign r2     = dtj_pkg::add_sat(p0_q, q_q);
  assign escape = !r2[QW-1] && (r2 > dtj_pkg::ESC_LIMIT);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dtj_pkg::ST_IDLE;
      step_q   <= dtj_pkg::STEP_SQ_ZR;
      ph_q     <= dtj_pkg::PH_LATCH;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      ph_q     <= ph_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      inside_q <= inside_d;
    end
  end

  // next state and result strobe
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    inside_d = inside_q;
    case (state_q)
      dtj_pkg::ST_IDLE: begin
        if (start) begin
          state_d = dtj_pkg::ST_INIT_X;
          cnt_d   = '0;
        end
      end
      dtj_pkg::ST_INIT_X:  state_d = dtj_pkg::ST_INIT_XY;
      dtj_pkg::ST_INIT_XY: state_d = dtj_pkg::ST_INIT_Y;
      dtj_pkg::ST_INIT_Y: begin
        state_d = dtj_pkg::ST_MUL;
        step_d  = dtj_pkg::STEP_SQ_ZR;
        ph_d    = dtj_pkg::PH_LATCH;
      end
      dtj_pkg::ST_MUL: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == dtj_pkg::PH_ACT) begin
          if (step_q == dtj_pkg::STEP_SQ_ZI && escape) begin
            state_d  = dtj_pkg::ST_IDLE;
            done_d   = 1'b1;
            inside_d = 1'b0;
          end else if (step_q == dtj_pkg::STEP_M_IR) begin
            state_d = dtj_pkg::ST_UPDATE;
          end else begin
            step_d = dtj_pkg::step_e'(step_q + 4'd1);
          end
        end
      end
      dtj_pkg::ST_UPDATE: begin
        cnt_d = cnt_q + dtj_pkg::CNT_W'(1);
        if (cnt_d == dtj_pkg::CNT_W'(dtj_pkg::MAX_ITER)) begin
          state_d  = dtj_pkg::ST_IDLE;
          done_d   = 1'b1;
          inside_d = 1'b1;
        end else begin
          state_d = dtj_pkg::ST_MUL;
          step_d  = dtj_pkg::STEP_SQ_ZR;
          ph_d    = dtj_pkg::PH_LATCH;
        end
      end
      default: state_d = dtj_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      dtj_pkg::ST_IDLE: begin
        if (start) begin
          px_q <= pixel_x_i;
          py_q <= pixel_y_i;
        end
      end
      // start point: pixel times step plus origin
      dtj_pkg::ST_INIT_XY: zr_q <= dtj_pkg::add_sat(QW'(prod_q[36:0]), origin_re_q);
      dtj_pkg::ST_INIT_Y:  zi_q <= dtj_pkg::add_sat(QW'(prod_q[36:0]), origin_im_q);
      dtj_pkg::ST_MUL: begin
        case (ph_q)
          dtj_pkg::PH_LATCH: begin
            ma_q  <= dtj_pkg::mag(op_a);
            mb_q  <= dtj_pkg::mag(op_b);
            neg_q <= op_a[QW-1] ^ op_b[QW-1];
          end
          dtj_pkg::PH_HL: begin
            acc_q    <= {prod_q[dtj_pkg::ACC_W-dtj_pkg::FRAC-1:0], {dtj_pkg::FRAC{1'b0}}};
            hi_ovf_q <= (prod_q[dtj_pkg::PW-1:dtj_pkg::FRAC-1] != '0);
          end
          dtj_pkg::PH_LH, dtj_pkg::PH_LL: acc_q <= acc_q + dtj_pkg::ACC_W'(prod_q);
          dtj_pkg::PH_TAIL:
            acc_q <= acc_q + dtj_pkg::ACC_W'(prod_q[dtj_pkg::PW-1:dtj_pkg::FRAC]);
          dtj_pkg::PH_ROUND: q_q <= rnd_val;
          dtj_pkg::PH_ACT: begin
            // combine the finished product per step
            case (step_q)
              dtj_pkg::STEP_SQ_ZR:  p0_q  <= q_q;
              dtj_pkg::STEP_SQ_ZI:  s2r_q <= dtj_pkg::sub_sat(p0_q, q_q);
              dtj_pkg::STEP_X_Z:    s2i_q <= dtj_pkg::add_sat(q_q, q_q);
              dtj_pkg::STEP_SQ_S2R: p0_q  <= q_q;
              dtj_pkg::STEP_SQ_S2I: wr_q  <= dtj_pkg::sub_sat(p0_q, q_q);
              dtj_pkg::STEP_X_S2:   wi_q  <= dtj_pkg::add_sat(q_q, q_q);
              dtj_pkg::STEP_SQ_WR:  p0_q  <= q_q;
              dtj_pkg::STEP_SQ_WI:  tr_q  <= dtj_pkg::sub_sat(p0_q, q_q);
              dtj_pkg::STEP_X_W: begin
                wr_q <= tr_q;
                wi_q <= dtj_pkg::add_sat(q_q, q_q);
              end
              dtj_pkg::STEP_M_RR:   p0_q  <= q_q;
              dtj_pkg::STEP_M_II:   tr_q  <= dtj_pkg::sub_sat(p0_q, q_q);
              dtj_pkg::STEP_M_RI:   p0_q  <= q_q;
              dtj_pkg::STEP_M_IR:   wi_q  <= dtj_pkg::add_sat(p0_q, q_q);
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      // z = z^10 + c
      dtj_pkg::ST_UPDATE: begin
        zr_q <= dtj_pkg::add_sat(tr_q, const_re_q);
        zi_q <= dtj_pkg::add_sat(wi_q, const_im_q);
      end
      default: ;
    endcase
  end

  // outputs
  assign busy         = (state_q != dtj_pkg::ST_IDLE);
  assign done_o       = done_q;
  assign out_x_o      = px_q;
  assign out_y_o      = py_q;
  assign iterations_o = dtj_pkg::ITER_W'(cnt_q);
  assign inside_res_o = inside_q;

  // checks
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted pixel did not start work");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without work in progress");

  a_inside_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inside_res_o) |-> (cnt_q == dtj_pkg::CNT_W'(dtj_pkg::MAX_ITER)))
    else $error("inside flag without reaching the limit");

endmodule
